>>> rtl/core/crs_pkg.sv
// crs_pkg: shared types, codes and the wire type table for the compact rpc serializer
// used by crs_dp, crs_ctrl and compact_rpc_serializer; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package crs_pkg;

	localparam logic [3:0] CMD_MSG   = 4'd0;
	localparam logic [3:0] CMD_SBEG  = 4'd1;
	localparam logic [3:0] CMD_SEND  = 4'd2;
	localparam logic [3:0] CMD_FIELD = 4'd3;
	localparam logic [3:0] CMD_STOP  = 4'd4;
	localparam logic [3:0] CMD_BOOL  = 4'd5;
	localparam logic [3:0] CMD_BYTE  = 4'd6;
	localparam logic [3:0] CMD_I16   = 4'd7;
	localparam logic [3:0] CMD_I32   = 4'd8;
	localparam logic [3:0] CMD_I64   = 4'd9;
	localparam logic [3:0] CMD_DBL   = 4'd10;
	localparam logic [3:0] CMD_LIST  = 4'd11;
	localparam logic [3:0] CMD_MAP   = 4'd12;
	localparam logic [3:0] CMD_LEN   = 4'd13;

	localparam logic [3:0] WT_BOOL = 4'd2;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_OVF  = 2'd1;
	localparam logic [1:0] ERR_TYPE = 2'd2;

	localparam logic [3:0] CT_TRUE  = 4'h1;
	localparam logic [3:0] CT_FALSE = 4'h2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_START, ST_PRE0, ST_PRE1, ST_VAR1, ST_VAR2, ST_POST
	} state_t;

	typedef enum logic [1:0] {SEL_PRE0, SEL_PRE1, SEL_VAR, SEL_POST} byte_sel_t;

	typedef struct packed {
		logic has_pre0;
		logic has_pre1;
		logic has_v1;
		logic has_v2;
		logic has_post;
		logic pop;
		logic v_more;
		logic out_free;
	} dp_status_t;

	typedef struct packed {
		logic      emit;
		byte_sel_t sel;
		logic      last;
		logic      shift;
		logic      load_v2;
		logic      pop;
	} dp_cmd_t;

	// returns {invalid, compact code}
	function automatic logic [4:0] type_map(input logic [3:0] t);
		logic [4:0] r;
		begin
			case (t)
				4'd0:  r = 5'h00;
				4'd2:  r = 5'h01;
				4'd3:  r = 5'h03;
				4'd4:  r = 5'h07;
				4'd6:  r = 5'h04;
				4'd8:  r = 5'h05;
				4'd10: r = 5'h06;
				4'd11: r = 5'h08;
				4'd12: r = 5'h0C;
				4'd13: r = 5'h0B;
				4'd14: r = 5'h0A;
				4'd15: r = 5'h09;
				default: r = 5'h10;
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/compact_rpc_serializer.sv
// compact_rpc_serializer: top level of the compact binary rpc encoder
// depends on crs_pkg, crs_ctrl, crs_dp and crs_ram
//
//   channel  signals                                       direction
//   input    in_valid/in_stall, command..name_length       request in
//   output   out_valid/out_stall, out_byte, last, error    one byte per result
//
// a request is taken, passes the dispatch state, then goes out one byte per cycle while out_stall is low
// a request yields at most 12 result bytes, walked by the byte sequencer
// struct end with a saved id reads the stack ram in the dispatch cycle
// out_stall holds the output register and the sequencer; reset clears all control state
`timescale 1ns / 1ps
`default_nettype none
module compact_rpc_serializer #(
	parameter int unsigned NEST_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [3:0]         command,
	input  wire logic signed [63:0] value,
	input  wire logic [3:0]         field_type,
	input  wire logic [3:0]         value_type,
	input  wire logic signed [15:0] field_id,
	input  wire logic [2:0]         message_kind,
	input  wire logic [31:0]        name_length,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              out_byte,
	output logic                    last,
	output logic [1:0]              error
);
	logic                accept;
	crs_pkg::dp_status_t st;
	crs_pkg::dp_cmd_t    cmd;

	crs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.accept   (accept),
		.st       (st),
		.cmd      (cmd)
	);

	crs_dp #(.NEST_DEPTH(NEST_DEPTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.command      (command),
		.value        (value),
		.field_type   (field_type),
		.value_type   (value_type),
		.field_id     (field_id),
		.message_kind (message_kind),
		.name_length  (name_length),
		.cmd          (cmd),
		.st           (st),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.out_byte     (out_byte),
		.last         (last),
		.error        (error)
	);
endmodule
`default_nettype wire

>>> rtl/core/crs_ram.sv
// crs_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module crs_ram #(
	parameter int unsigned W = 16,
	parameter int unsigned D = 16,
	localparam int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/core/crs_dp.sv
// crs_dp: token decode, field id state, id stack, byte shifter and output register
// depends on crs_pkg and crs_ram
`timescale 1ns / 1ps
`default_nettype none
module crs_dp #(
	parameter int unsigned NEST_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [3:0]         command,
	input  wire logic signed [63:0] value,
	input  wire logic [3:0]         field_type,
	input  wire logic [3:0]         value_type,
	input  wire logic signed [15:0] field_id,
	input  wire logic [2:0]         message_kind,
	input  wire logic [31:0]        name_length,
	input  wire crs_pkg::dp_cmd_t   cmd,
	output crs_pkg::dp_status_t     st,
	input  wire logic               out_stall,
	output logic                    out_valid,
	output logic [7:0]              out_byte,
	output logic                    last,
	output logic [1:0]              error
);
	localparam int unsigned LW = $clog2(NEST_DEPTH + 1);
	localparam int unsigned AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

	logic [15:0]   prev_q, pid_q;
	logic          pending_q;
	logic [LW-1:0] level_q, level_m1;
	logic [15:0]   stack_rd;
	logic          push;

	logic [7:0]  pre0_q, pre1_q, post_q;
	logic [63:0] v_q;
	logic [31:0] v2_q;
	logic        has_pre0_q, has_pre1_q, has_v1_q, has_v2_q, has_post_q, pop_q, raw_q;
	logic [2:0]  cnt_q;
	logic [1:0]  err_q;

	logic [7:0]  pre0_d, pre1_d, post_d;
	logic [63:0] v1_d;
	logic [31:0] v2_d;
	logic        has_pre0_d, has_pre1_d, has_v1_d, has_v2_d, has_post_d, pop_d, raw_d;
	logic [1:0]  err_d;

	logic [4:0]  tm_f, tm_v;
	logic [3:0]  hdr_ct, bool_ct;
	logic [15:0] hdr_id;
	logic [16:0] diff;
	logic        hdr_short;
	logic [31:0] id32, id_zz, i16_32, cnt32;
	logic        v_more;
	logic [7:0]  emit_byte;

	assign tm_f     = crs_pkg::type_map(field_type);
	assign tm_v     = crs_pkg::type_map(value_type);
	assign bool_ct  = value[0] ? crs_pkg::CT_TRUE : crs_pkg::CT_FALSE;
	assign hdr_ct   = (command == crs_pkg::CMD_FIELD) ? tm_f[3:0] : bool_ct;
	assign hdr_id   = (command == crs_pkg::CMD_FIELD) ? field_id : pid_q;
	assign diff     = {hdr_id[15], hdr_id} - {prev_q[15], prev_q};
	// delta 1..15 takes the short header form
	assign hdr_short = !diff[16] && (diff[15:4] == 12'd0) && (diff[3:0] != 4'd0);
	assign id32     = {{16{hdr_id[15]}}, hdr_id};
	assign id_zz    = {id32[30:0], 1'b0} ^ {32{id32[31]}};
	assign i16_32   = {{16{value[15]}}, value[15:0]};
	assign cnt32    = (value[63:32] != 32'd0) ? 32'hFFFF_FFFF : value[31:0];
	assign level_m1 = level_q - LW'(1);
	assign push     = accept && (command == crs_pkg::CMD_SBEG)
		&& (level_q != LW'(NEST_DEPTH));

	crs_ram #(.W(16), .D(NEST_DEPTH)) u_stack (
		.clk   (clk),
		.we    (push),
		.waddr (level_q[AW-1:0]),
		.wdata (prev_q),
		.raddr (level_m1[AW-1:0]),
		.rdata (stack_rd)
	);

	always_comb begin
		pre0_d = 8'h00; pre1_d = 8'h00; post_d = 8'h00;
		v1_d = 64'd0; v2_d = 32'd0;
		has_pre0_d = 1'b0; has_pre1_d = 1'b0; has_v1_d = 1'b0;
		has_v2_d = 1'b0; has_post_d = 1'b0; pop_d = 1'b0; raw_d = 1'b0;
		err_d = crs_pkg::ERR_NONE;
		unique case (command)
			crs_pkg::CMD_MSG: begin
				pre0_d = 8'h82; has_pre0_d = 1'b1;
				pre1_d = {message_kind, 5'h01}; has_pre1_d = 1'b1;
				v1_d = {32'd0, value[31:0]}; has_v1_d = 1'b1;
				v2_d = name_length; has_v2_d = 1'b1;
			end
			crs_pkg::CMD_SBEG: begin
				if (level_q == LW'(NEST_DEPTH)) begin
					err_d = crs_pkg::ERR_OVF; has_pre0_d = 1'b1;
				end
			end
			crs_pkg::CMD_SEND: pop_d = (level_q != LW'(0));
			crs_pkg::CMD_FIELD, crs_pkg::CMD_BOOL: begin
				if (command == crs_pkg::CMD_FIELD && field_type == crs_pkg::WT_BOOL) begin
					has_pre0_d = 1'b0;
				end else if (command == crs_pkg::CMD_FIELD && tm_f[4]) begin
					err_d = crs_pkg::ERR_TYPE; has_pre0_d = 1'b1;
				end else if (command == crs_pkg::CMD_BOOL && !pending_q) begin
					pre0_d = {4'h0, bool_ct}; has_pre0_d = 1'b1;
				end else begin
					has_pre0_d = 1'b1;
					pre0_d = hdr_short ? {diff[3:0], hdr_ct} : {4'h0, hdr_ct};
					has_v1_d = !hdr_short;
					v1_d = {32'd0, id_zz};
				end
			end
			crs_pkg::CMD_STOP: has_pre0_d = 1'b1;
			crs_pkg::CMD_BYTE: begin
				pre0_d = value[7:0]; has_pre0_d = 1'b1;
			end
			crs_pkg::CMD_I16: begin
				v1_d = {32'd0, {i16_32[30:0], 1'b0} ^ {32{i16_32[31]}}};
				has_v1_d = 1'b1;
			end
			crs_pkg::CMD_I32: begin
				v1_d = {32'd0, {value[30:0], 1'b0} ^ {32{value[31]}}};
				has_v1_d = 1'b1;
			end
			crs_pkg::CMD_I64: begin
				v1_d = {value[62:0], 1'b0} ^ {64{value[63]}};
				has_v1_d = 1'b1;
			end
			crs_pkg::CMD_DBL: begin
				v1_d = value; has_v1_d = 1'b1; raw_d = 1'b1;
			end
			crs_pkg::CMD_LIST: begin
				has_pre0_d = 1'b1;
				if (tm_f[4]) begin
					err_d = crs_pkg::ERR_TYPE;
				end else if (value[63:4] == 60'd0 && value[3:0] != 4'hF) begin
					pre0_d = {value[3:0], tm_f[3:0]};
				end else begin
					pre0_d = {4'hF, tm_f[3:0]};
					v1_d = {32'd0, cnt32}; has_v1_d = 1'b1;
				end
			end
			crs_pkg::CMD_MAP: begin
				if (value == 64'sd0) begin
					has_pre0_d = 1'b1;
				end else if (tm_f[4] || tm_v[4]) begin
					err_d = crs_pkg::ERR_TYPE; has_pre0_d = 1'b1;
				end else begin
					v1_d = {32'd0, cnt32}; has_v1_d = 1'b1;
					post_d = {tm_f[3:0], tm_v[3:0]}; has_post_d = 1'b1;
				end
			end
			crs_pkg::CMD_LEN: begin
				v1_d = {32'd0, cnt32}; has_v1_d = 1'b1;
			end
			default: has_pre0_d = 1'b0;
		endcase
	end

	// field id state moves at accept; a pop lands in the dispatch cycle after it, from the stack ram
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 16'd0; level_q <= '0; pending_q <= 1'b0;
		end else if (accept) begin
			unique case (command)
				crs_pkg::CMD_SBEG: begin
					if (level_q != LW'(NEST_DEPTH)) begin
						level_q <= level_q + LW'(1);
						prev_q  <= 16'd0;
					end
				end
				crs_pkg::CMD_SEND: begin
					if (level_q != LW'(0)) begin
						level_q <= level_m1;
					end else begin
						prev_q <= 16'd0;
					end
				end
				crs_pkg::CMD_FIELD: begin
					if (field_type == crs_pkg::WT_BOOL) begin
						pending_q <= 1'b1;
					end else if (!tm_f[4]) begin
						prev_q <= field_id;
					end
				end
				crs_pkg::CMD_BOOL: begin
					if (pending_q) begin
						pending_q <= 1'b0;
						prev_q    <= pid_q;
					end
				end
				default: prev_q <= prev_q;
			endcase
		end else if (cmd.pop) begin
			prev_q <= stack_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && command == crs_pkg::CMD_FIELD && field_type == crs_pkg::WT_BOOL) begin
			pid_q <= field_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_pre0_q <= 1'b0; has_pre1_q <= 1'b0; has_v1_q <= 1'b0;
			has_v2_q <= 1'b0; has_post_q <= 1'b0; pop_q <= 1'b0; raw_q <= 1'b0;
			err_q <= crs_pkg::ERR_NONE; cnt_q <= 3'd0;
		end else if (accept) begin
			has_pre0_q <= has_pre0_d; has_pre1_q <= has_pre1_d; has_v1_q <= has_v1_d;
			has_v2_q <= has_v2_d; has_post_q <= has_post_d; pop_q <= pop_d;
			raw_q <= raw_d; err_q <= err_d; cnt_q <= 3'd0;
		end else if (cmd.load_v2) begin
			raw_q <= 1'b0; cnt_q <= 3'd0;
		end else if (cmd.shift) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pre0_q <= pre0_d; pre1_q <= pre1_d; post_q <= post_d;
			v_q <= v1_d; v2_q <= v2_d;
		end else if (cmd.load_v2) begin
			v_q <= {32'd0, v2_q};
		end else if (cmd.shift) begin
			v_q <= raw_q ? {8'd0, v_q[63:8]} : {7'd0, v_q[63:7]};
		end
	end

	assign v_more = raw_q ? (cnt_q != 3'd7) : (v_q[63:7] != 57'd0);

	always_comb begin
		case (cmd.sel)
			crs_pkg::SEL_PRE0: emit_byte = pre0_q;
			crs_pkg::SEL_PRE1: emit_byte = pre1_q;
			crs_pkg::SEL_VAR:  emit_byte = raw_q ? v_q[7:0] : {v_more, v_q[6:0]};
			default:           emit_byte = post_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte <= emit_byte;
			last     <= cmd.last;
			error    <= err_q;
		end
	end

	assign st.has_pre0 = has_pre0_q;
	assign st.has_pre1 = has_pre1_q;
	assign st.has_v1   = has_v1_q;
	assign st.has_v2   = has_v2_q;
	assign st.has_post = has_post_q;
	assign st.pop      = pop_q;
	assign st.v_more   = v_more;
	assign st.out_free = !out_valid || !out_stall;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LW'(NEST_DEPTH))
		else $error("stack level beyond nest depth");
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		accept && err_d != crs_pkg::ERR_NONE |=> has_pre0_q && !has_pre1_q && !has_v1_q)
		else $error("error token carries more than one byte");
	a_raw_v1: assert property (@(posedge clk) disable iff (!arst_n)
		raw_q |-> !has_v2_q)
		else $error("raw double with second varint");
endmodule
`default_nettype wire

>>> rtl/core/crs_ctrl.sv
// crs_ctrl: sequencer that walks the byte segments of one request
// depends on crs_pkg
`timescale 1ns / 1ps
`default_nettype none
module crs_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic                    accept,
	input  wire crs_pkg::dp_status_t st,
	output crs_pkg::dp_cmd_t        cmd
);
	crs_pkg::state_t state_q, state_d;
	crs_pkg::state_t nx_start, nx_pre0, nx_pre1, nx_v1, nx_v2;

	assign in_stall = (state_q != crs_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// next segment present after each position
	assign nx_v2    = st.has_post ? crs_pkg::ST_POST : crs_pkg::ST_IDLE;
	assign nx_v1    = st.has_v2 ? crs_pkg::ST_VAR2 : nx_v2;
	assign nx_pre1  = st.has_v1 ? crs_pkg::ST_VAR1 : nx_v1;
	assign nx_pre0  = st.has_pre1 ? crs_pkg::ST_PRE1 : nx_pre1;
	assign nx_start = st.has_pre0 ? crs_pkg::ST_PRE0 : nx_pre0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			crs_pkg::ST_IDLE:  if (accept) state_d = crs_pkg::ST_START;
			crs_pkg::ST_START: state_d = nx_start;
			crs_pkg::ST_PRE0:  if (st.out_free) state_d = nx_pre0;
			crs_pkg::ST_PRE1:  if (st.out_free) state_d = nx_pre1;
			crs_pkg::ST_VAR1:  if (st.out_free && !st.v_more) state_d = nx_v1;
			crs_pkg::ST_VAR2:  if (st.out_free && !st.v_more) state_d = nx_v2;
			crs_pkg::ST_POST:  if (st.out_free) state_d = crs_pkg::ST_IDLE;
			default:           state_d = crs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.sel = crs_pkg::SEL_PRE0;
		unique case (state_q)
			crs_pkg::ST_IDLE: cmd.emit = 1'b0;
			crs_pkg::ST_START: cmd.pop = st.pop;
			crs_pkg::ST_PRE0: begin
				cmd.emit = st.out_free;
				cmd.last = (nx_pre0 == crs_pkg::ST_IDLE);
			end
			crs_pkg::ST_PRE1: begin
				cmd.emit = st.out_free;
				cmd.sel  = crs_pkg::SEL_PRE1;
				cmd.last = (nx_pre1 == crs_pkg::ST_IDLE);
			end
			crs_pkg::ST_VAR1: begin
				cmd.emit    = st.out_free;
				cmd.sel     = crs_pkg::SEL_VAR;
				cmd.shift   = st.out_free;
				cmd.last    = !st.v_more && (nx_v1 == crs_pkg::ST_IDLE);
				cmd.load_v2 = st.out_free && !st.v_more && st.has_v2;
			end
			crs_pkg::ST_VAR2: begin
				cmd.emit  = st.out_free;
				cmd.sel   = crs_pkg::SEL_VAR;
				cmd.shift = st.out_free;
				cmd.last  = !st.v_more && (nx_v2 == crs_pkg::ST_IDLE);
			end
			crs_pkg::ST_POST: begin
				cmd.emit = st.out_free;
				cmd.sel  = crs_pkg::SEL_POST;
				cmd.last = 1'b1;
			end
			default: cmd.emit = 1'b0;
		endcase
	end

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == crs_pkg::ST_START)
		else $error("request not followed by dispatch");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("byte emitted into a full output register");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.last |=> state_q == crs_pkg::ST_IDLE)
		else $error("last byte emitted but segments remain");
endmodule
`default_nettype wire

>>> verif/compact_rpc_serializer_tb.sv
// compact_rpc_serializer_tb: self-checking bench for the compact rpc serializer
// drives directed and random tokens, predicts the encoded bytes, checks each output byte
// depends on crs_pkg and compact_rpc_serializer
`timescale 1ns / 1ps
module compact_rpc_serializer_tb;

	typedef struct {
		logic [7:0] data;
		logic       fin;
		logic [1:0] code;
	} enc_byte_t;

	typedef struct {
		logic [3:0]  cmd;
		logic [63:0] val;
		logic [3:0]  ftype;
		logic [3:0]  vtype;
		logic [15:0] fid;
		logic [2:0]  kind;
		logic [31:0] nlen;
		int          rep;
		int          n_typed;
		logic [7:0]  tb0, tb1, tb2;
		logic [1:0]  terr;
	} token_row_t;

	localparam logic [3:0] CMD_NOP14 = 4'd14;
	localparam logic [3:0] CMD_NOP15 = 4'd15;
	localparam int DEPTH = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [3:0] command = '0;
	logic signed [63:0] value = '0;
	logic [3:0] field_type = '0;
	logic [3:0] value_type = '0;
	logic signed [15:0] field_id = '0;
	logic [2:0] message_kind = '0;
	logic [31:0] name_length = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_byte;
	logic last;
	logic [1:0] error;

	compact_rpc_serializer u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .value(value), .field_type(field_type),
		.value_type(value_type), .field_id(field_id),
		.message_kind(message_kind), .name_length(name_length),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_byte(out_byte), .last(last), .error(error)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [15:0] prev_id;
	logic [15:0] id_stack [DEPTH];
	int          nest_level;
	logic        bool_wait;
	logic [15:0] bool_id;

	enc_byte_t expected_bytes_q[$];
	logic [7:0] token_bytes[$];
	int mismatches = 0;

	// typed expectations for the current directed row
	int         typed_n = 0;
	logic [7:0] typed_b[3];
	logic [1:0] typed_err;

	int idle_pct = 0;
	int stall_pct = 0;
	logic hold_go = 1'b0;
	logic hold_used = 1'b0;
	int hold_left = 0;

	function automatic logic [7:0] compact_code(input logic [3:0] t);
		case (t)
			4'd0: return 8'h00;
			4'd2: return 8'h01;
			4'd3: return 8'h03;
			4'd4: return 8'h07;
			4'd6: return 8'h04;
			4'd8: return 8'h05;
			4'd10: return 8'h06;
			4'd11: return 8'h08;
			4'd12: return 8'h0C;
			4'd13: return 8'h0B;
			4'd14: return 8'h0A;
			4'd15: return 8'h09;
			default: return 8'hFF;
		endcase
	endfunction

	function automatic logic [31:0] zigzag32(input logic [31:0] u);
		return (u << 1) ^ {32{u[31]}};
	endfunction

	function automatic logic [63:0] sat_count(input logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
	endfunction

	task automatic add_varint(input logic [63:0] v);
		while (v >= 64'h80) begin
			token_bytes.push_back({1'b1, v[6:0]});
			v = v >> 7;
		end
		token_bytes.push_back(v[7:0]);
	endtask

	task automatic add_field_header(input logic [7:0] ctype, input logic [15:0] id);
		int delta;
		delta = int'($signed(id)) - int'($signed(prev_id));
		if (delta >= 1 && delta <= 15) begin
			token_bytes.push_back(8'(delta << 4) | ctype);
		end else begin
			token_bytes.push_back(ctype);
			add_varint({32'd0, zigzag32({{16{id[15]}}, id})});
		end
		prev_id = id;
	endtask

	// works out the encoded bytes of one accepted token and queues them
	task automatic encode_token(input logic [3:0] cmd, input logic [63:0] v,
			input logic [3:0] ft, input logic [3:0] vt, input logic [15:0] fid,
			input logic [2:0] kind, input logic [31:0] nlen);
		logic [1:0] fault;
		enc_byte_t e;
		fault = crs_pkg::ERR_NONE;
		token_bytes.delete();
		case (cmd)
			crs_pkg::CMD_MSG: begin
				token_bytes.push_back(8'h82);
				token_bytes.push_back({kind, 5'h01});
				add_varint({32'd0, v[31:0]});
				add_varint({32'd0, nlen});
			end
			crs_pkg::CMD_SBEG: begin
				if (nest_level >= DEPTH) begin
					fault = crs_pkg::ERR_OVF;
				end else begin
					id_stack[nest_level] = prev_id;
					nest_level++;
					prev_id = '0;
				end
			end
			crs_pkg::CMD_SEND: begin
				if (nest_level > 0) begin
					nest_level--;
					prev_id = id_stack[nest_level];
				end else begin
					prev_id = '0;
				end
			end
			crs_pkg::CMD_FIELD: begin
				if (ft == crs_pkg::WT_BOOL) begin
					bool_wait = 1'b1;
					bool_id = fid;
				end else if (compact_code(ft) == 8'hFF) begin
					fault = crs_pkg::ERR_TYPE;
				end else begin
					add_field_header(compact_code(ft), fid);
				end
			end
			crs_pkg::CMD_STOP: token_bytes.push_back(8'h00);
			crs_pkg::CMD_BOOL: begin
				if (bool_wait) begin
					bool_wait = 1'b0;
					add_field_header(v[0] ? 8'h01 : 8'h02, bool_id);
				end else begin
					token_bytes.push_back(v[0] ? 8'h01 : 8'h02);
				end
			end
			crs_pkg::CMD_BYTE: token_bytes.push_back(v[7:0]);
			crs_pkg::CMD_I16: add_varint({32'd0, zigzag32({{16{v[15]}}, v[15:0]})});
			crs_pkg::CMD_I32: add_varint({32'd0, zigzag32(v[31:0])});
			crs_pkg::CMD_I64: add_varint((v << 1) ^ {64{v[63]}});
			crs_pkg::CMD_DBL: for (int k = 0; k < 8; k++) token_bytes.push_back(v[8*k +: 8]);
			crs_pkg::CMD_LIST: begin
				if (compact_code(ft) == 8'hFF) begin
					fault = crs_pkg::ERR_TYPE;
				end else if (v <= 64'd14) begin
					token_bytes.push_back({v[3:0], 4'h0} | compact_code(ft));
				end else begin
					token_bytes.push_back(8'hF0 | compact_code(ft));
					add_varint(sat_count(v));
				end
			end
			crs_pkg::CMD_MAP: begin
				if (v == 64'd0) begin
					token_bytes.push_back(8'h00);
				end else if (compact_code(ft) == 8'hFF || compact_code(vt) == 8'hFF) begin
					fault = crs_pkg::ERR_TYPE;
				end else begin
					add_varint(sat_count(v));
					token_bytes.push_back(8'((compact_code(ft) << 4) | compact_code(vt)));
				end
			end
			crs_pkg::CMD_LEN: add_varint(sat_count(v));
			default: ;
		endcase
		if (typed_n > 0) begin
			token_bytes.delete();
			fault = typed_err;
			for (int k = 0; k < typed_n; k++) token_bytes.push_back(typed_b[k]);
		end
		if (fault != crs_pkg::ERR_NONE) begin
			e.data = 8'h00; e.fin = 1'b1; e.code = fault;
			expected_bytes_q.push_back(e);
		end else begin
			foreach (token_bytes[k]) begin
				e.data = token_bytes[k];
				e.fin = (k == token_bytes.size() - 1);
				e.code = crs_pkg::ERR_NONE;
				expected_bytes_q.push_back(e);
			end
		end
	endtask

	// request acceptance and output checking, both sampled at the rising edge
	always @(posedge clk) begin
		enc_byte_t e;
		if (arst_n && in_valid && !in_stall)
			encode_token(command, value, field_type, value_type, field_id,
				message_kind, name_length);
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected byte %h last %b error %0d", out_byte, last, error);
			end else begin
				e = expected_bytes_q.pop_front();
				if (out_byte !== e.data || last !== e.fin || error !== e.code) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp byte %h last %b error %0d, got %h %b %0d",
							e.data, e.fin, e.code, out_byte, last, error);
				end
			end
		end
	end

	// receiver side: random stalls plus one long hold-off counted here
	always @(negedge clk) begin
		if (hold_go && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= 299;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_token(input logic [3:0] cmd, input logic [63:0] v,
			input logic [3:0] ft, input logic [3:0] vt, input logic [15:0] fid,
			input logic [2:0] kind, input logic [31:0] nlen);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		command = cmd; value = v; field_type = ft; value_type = vt;
		field_id = fid; message_kind = kind; name_length = nlen;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic logic [63:0] rand_value();
		case ($urandom_range(5))
			0: return {$urandom, $urandom};
			1: return 64'($urandom_range(20));
			2: return {$urandom, $urandom} >> $urandom_range(63);
			3: return -64'($urandom_range(300));
			4: return 64'($urandom_range(255));
			default: return {32'd0, $urandom};
		endcase
	endfunction

	task automatic random_token();
		logic [3:0] cmd;
		logic [3:0] ft;
		logic [15:0] fid;
		int pick;
		pick = $urandom_range(99);
		if (pick < 8) cmd = crs_pkg::CMD_SBEG;
		else if (pick < 16) cmd = crs_pkg::CMD_SEND;
		else if (pick < 40) cmd = crs_pkg::CMD_FIELD;
		else if (pick < 46) cmd = crs_pkg::CMD_BOOL;
		else if (pick < 49) cmd = crs_pkg::CMD_MSG;
		else if (pick < 98) cmd = 4'($urandom_range(13));
		else cmd = 4'($urandom_range(15));
		ft = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'({$urandom_range(7), 1'b0});
		if ($urandom_range(3) == 0) ft = crs_pkg::WT_BOOL;
		case ($urandom_range(3))
			0: fid = 16'($urandom);
			1: fid = prev_id - 16'($urandom_range(3));
			default: fid = prev_id + 16'($urandom_range(1, 18));
		endcase
		send_token(cmd, rand_value(), ft, 4'($urandom_range(15)), fid,
			3'($urandom_range(7)), $urandom_range(1) ? $urandom : 32'($urandom_range(200)));
	endtask

	token_row_t rows[$];

	function automatic token_row_t row(input logic [3:0] cmd, input logic [63:0] v,
			input logic [3:0] ft, input logic [3:0] vt, input logic [15:0] fid,
			input logic [2:0] kind, input logic [31:0] nlen, input int rep, input int n,
			input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
			input logic [1:0] terr);
		token_row_t r;
		r.cmd = cmd; r.val = v; r.ftype = ft; r.vtype = vt; r.fid = fid;
		r.kind = kind; r.nlen = nlen; r.rep = rep; r.n_typed = n;
		r.tb0 = b0; r.tb1 = b1; r.tb2 = b2; r.terr = terr;
		return r;
	endfunction

	initial begin
		prev_id = '0;
		nest_level = 0;
		bool_wait = 1'b0;
		bool_id = '0;
		foreach (id_stack[k]) id_stack[k] = '0;

		// cmd, value, ft, vt, fid, kind, nlen / rep, n typed, b0, b1, b2, err
		rows.push_back(row(crs_pkg::CMD_STOP, 64'd0, 0, 0, 16'd0, 0, 32'd0,
			1, 1, 8'h00, 8'h00, 8'h00, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_BYTE, 64'hFF, 0, 0, 16'd0, 0, 32'd0,
			1, 1, 8'hFF, 8'h00, 8'h00, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_BOOL, 64'd1, 0, 0, 16'd0, 0, 32'd0,
			1, 1, 8'h01, 8'h00, 8'h00, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_BOOL, 64'd0, 0, 0, 16'd0, 0, 32'd0,
			1, 1, 8'h02, 8'h00, 8'h00, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_FIELD, 64'd0, 1, 0, 16'd3, 0, 32'd0,
			1, 1, 8'h00, 8'h00, 8'h00, crs_pkg::ERR_TYPE));
		rows.push_back(row(crs_pkg::CMD_LIST, 64'd3, 5, 0, 16'd0, 0, 32'd0,
			1, 1, 8'h00, 8'h00, 8'h00, crs_pkg::ERR_TYPE));
		rows.push_back(row(crs_pkg::CMD_MAP, 64'd0, 7, 9, 16'd0, 0, 32'd0,
			1, 1, 8'h00, 8'h00, 8'h00, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_MAP, 64'd2, 3, 9, 16'd0, 0, 32'd0,
			1, 1, 8'h00, 8'h00, 8'h00, crs_pkg::ERR_TYPE));
		rows.push_back(row(crs_pkg::CMD_I32, -64'sd1, 0, 0, 16'd0, 0, 32'd0,
			1, 1, 8'h01, 8'h00, 8'h00, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_I16, 64'h7FFF, 0, 0, 16'd0, 0, 32'd0,
			1, 3, 8'hFE, 8'hFF, 8'h03, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_I64, 64'h8000_0000_0000_0000, 0, 0, 16'd0, 0, 32'd0,
			1, 0, 0, 0, 0, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_I64, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 16'd0, 0, 32'd0,
			1, 0, 0, 0, 0, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_DBL, 64'hA5C3_0F1E_7788_9901, 0, 0, 16'd0, 0, 32'd0,
			1, 0, 0, 0, 0, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_MSG, -64'sd1, 0, 0, 16'd0, 7, 32'hFFFF_FFFF,
			1, 0, 0, 0, 0, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_FIELD, 64'd0, 8, 0, 16'd1, 0, 32'd0,
			1, 0, 0, 0, 0, crs_pkg::ERR_NONE));
		// pending bool field, replaced by a newer one before the value comes
		rows.push_back(row(crs_pkg::CMD_FIELD, 64'd0, 2, 0, 16'd5, 0, 32'd0,
			1, 0, 0, 0, 0, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_FIELD, 64'd0, 2, 0, 16'd40, 0, 32'd0,
			1, 0, 0, 0, 0, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_BOOL, 64'd1, 0, 0, 16'd0, 0, 32'd0,
			1, 0, 0, 0, 0, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_FIELD, 64'd0, 8, 0, 16'h8000, 0, 32'd0,
			1, 0, 0, 0, 0, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_LIST, 64'd14, 12, 0, 16'd0, 0, 32'd0,
			1, 0, 0, 0, 0, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_LIST, 64'h1_0000_0005, 12, 0, 16'd0, 0, 32'd0,
			1, 0, 0, 0, 0, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_MAP, 64'd300, 11, 15, 16'd0, 0, 32'd0,
			1, 0, 0, 0, 0, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_LEN, -64'sd1, 0, 0, 16'd0, 0, 32'd0,
			1, 0, 0, 0, 0, crs_pkg::ERR_NONE));
		// fill the id stack, overflow it, then unwind past empty
		rows.push_back(row(crs_pkg::CMD_SBEG, 64'd0, 0, 0, 16'd0, 0, 32'd0,
			16, 0, 0, 0, 0, crs_pkg::ERR_NONE));
		rows.push_back(row(crs_pkg::CMD_SBEG, 64'd0, 0, 0, 16'd0, 0, 32'd0,
			1, 1, 8'h00, 8'h00, 8'h00, crs_pkg::ERR_OVF));
		rows.push_back(row(crs_pkg::CMD_SEND, 64'd0, 0, 0, 16'd0, 0, 32'd0,
			17, 0, 0, 0, 0, crs_pkg::ERR_NONE));
		rows.push_back(row(CMD_NOP14, 64'd0, 0, 0, 16'd0, 0, 32'd0,
			1, 0, 0, 0, 0, crs_pkg::ERR_NONE));
		rows.push_back(row(CMD_NOP15, 64'd0, 0, 0, 16'd0, 0, 32'd0,
			1, 0, 0, 0, 0, crs_pkg::ERR_NONE));

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			typed_n = rows[i].n_typed;
			typed_b[0] = rows[i].tb0; typed_b[1] = rows[i].tb1; typed_b[2] = rows[i].tb2;
			typed_err = rows[i].terr;
			repeat (rows[i].rep)
				send_token(rows[i].cmd, rows[i].val, rows[i].ftype, rows[i].vtype,
					rows[i].fid, rows[i].kind, rows[i].nlen);
		end
		typed_n = 0;

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 70; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 70; end
				default: begin idle_pct = 15; stall_pct = 15; end
			endcase
			if (phase == 0) hold_go = 1'b1;
			for (int n = 0; n < 100; n++) begin
				random_token();
				// let everything drain once in the middle of a phase
				if (phase == 1 && n == 50) wait (expected_bytes_q.size() == 0);
			end
		end

		wait (expected_bytes_q.size() == 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_bytes_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

endmodule

>>> compact_rpc_serializer.f
rtl/core/crs_pkg.sv
rtl/core/crs_ram.sv
rtl/core/crs_dp.sv
rtl/core/crs_ctrl.sv
rtl/core/compact_rpc_serializer.sv
verif/compact_rpc_serializer_tb.sv
